// ===== sv/pbfp_pkg.sv =====
`default_nettype none
// ============================================================================
// pbfp_pkg
// Shared constants, command codes, beat types and helpers for the
// fixed-priority packet bus.
// ============================================================================
package pbfp_pkg;

    localparam int NUM_PORTS  = 16;
    localparam int BUS_BYTES  = 8;
    localparam int MAX_BEATS  = 8;
    localparam int PORT_W     = $clog2(NUM_PORTS);
    localparam int DATA_DEPTH = NUM_PORTS * MAX_BEATS;
    localparam int DADDR_W    = $clog2(DATA_DEPTH);
    localparam int MAX_LEN    = MAX_BEATS * BUS_BYTES;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_SEND   = 3'd1;
    localparam logic [2:0] CMD_TICK   = 3'd2;
    localparam logic [2:0] CMD_RECV   = 3'd3;
    localparam logic [2:0] CMD_STATUS = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  port;
        logic [3:0]  dest;
        logic [7:0]  msg_type;
        logic [63:0] line_addr;
        logic [31:0] msg_arg;
        logic [6:0]  byte_len;
        logic [2:0]  beat_index;
        logic [63:0] data_word;
    } in_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  src_port;
        logic [3:0]  out_dest;
        logic [3:0]  packet_index;
        logic        last;
        logic [7:0]  out_type;
        logic [63:0] out_line;
        logic [31:0] out_arg;
        logic [6:0]  out_len;
        logic [63:0] out_data;
        logic [3:0]  beat_bytes;
        logic        recv_free;
    } out_t;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [63:0] line_addr;
        logic [31:0] msg_arg;
        logic [6:0]  byte_len;
    } hdr_t;

    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] idx;
    } arb_t;

    function automatic logic [3:0] beats_of(logic [6:0] len);
        int n;
        n = (int'(len) + BUS_BYTES - 1) / BUS_BYTES;
        if (n > MAX_BEATS)
        begin
            n = MAX_BEATS;
        end
        return 4'(n);
    endfunction

    function automatic logic [3:0] bytes_of(logic [6:0] len, logic [3:0] b);
        int start;
        int rem;
        start = int'(b) * BUS_BYTES;
        if (int'(len) <= start)
        begin
            return 4'd0;
        end
        rem = int'(len) - start;
        if (rem > BUS_BYTES)
        begin
            rem = BUS_BYTES;
        end
        return 4'(rem);
    endfunction

    function automatic logic [63:0] byte_mask(logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[i*8 +: 8] = (i < int'(n)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [DADDR_W-1:0] data_addr(logic [PORT_W-1:0] p,
                                                     logic [3:0] b);
        return DADDR_W'(int'(p) * MAX_BEATS + int'(b));
    endfunction

endpackage
`default_nettype wire

// ===== sv/pbfp_if.sv =====
`default_nettype none
// ============================================================================
// pbfp_if
// Valid/ready channels for command beats and result beats.
// ============================================================================
interface pbfp_in_if;
    logic          valid;
    logic          ready;
    pbfp_pkg::in_t pay;
    modport source (output valid, output pay, input ready);
    modport sink   (input valid, input pay, output ready);
endinterface

interface pbfp_out_if;
    logic           valid;
    logic           ready;
    pbfp_pkg::out_t pay;
    modport source (output valid, output pay, input ready);
    modport sink   (input valid, input pay, output ready);
endinterface
`default_nettype wire

// ===== sv/pbfp_ram.sv =====
`default_nettype none
// ============================================================================
// pbfp_ram
// Simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module pbfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/pbfp_arb.sv =====
`default_nettype none
// ============================================================================
// pbfp_arb
// Fixed-priority pick: lowest pending port whose destination slot is free.
// ============================================================================
module pbfp_arb (
    input  wire logic [pbfp_pkg::NUM_PORTS-1:0] pend,
    input  wire logic [pbfp_pkg::NUM_PORTS-1:0] full,
    input  wire logic [pbfp_pkg::PORT_W-1:0]    dst [pbfp_pkg::NUM_PORTS],
    output      pbfp_pkg::arb_t                 pick
);

    logic [pbfp_pkg::NUM_PORTS-1:0] elig;

    always_comb
    begin
        for (int i = 0; i < pbfp_pkg::NUM_PORTS; i++)
        begin
            elig[i] = pend[i] && !full[dst[i]];
        end
    end

    always_comb
    begin
        pick = '0;
        for (int i = pbfp_pkg::NUM_PORTS - 1; i >= 0; i--)
        begin
            if (elig[i])
            begin
                pick.found = 1'b1;
                pick.idx   = pbfp_pkg::PORT_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/packet_bus_fixed_priority.sv =====
`default_nettype none
// ============================================================================
// packet_bus_fixed_priority
// Multi-port message bus: per-port send buffers, fixed-priority arbitration
// with burst lock, per-port receive slots, all held in block RAM.
// ============================================================================
//   channel  dir  beat
//   req      in   one command (load, send, tick, receive, status)
//   rsp      out  one result; a full receive gives header plus data beats
//
// Load, send, status, idle tick and empty receive are answered from idle. A tick
// that moves a packet reads the header/data RAM, then copies to the receive RAM.
// A full receive gives the header, then one RAM read per data beat.
// One command in flight at a time; a stalled rsp holds the sequencer.
// Reset clears pending/full flags and the bus lock; buffers are not cleared.
module packet_bus_fixed_priority (
    input wire logic   clk,
    input wire logic   rst_n,
    pbfp_in_if.sink    req,
    pbfp_out_if.source rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_RHDR = 2'd2;
    localparam logic [1:0] S_RDAT = 2'd3;

    localparam int PW = pbfp_pkg::PORT_W;
    localparam int NP = pbfp_pkg::NUM_PORTS;
    localparam int AW = pbfp_pkg::DADDR_W;

    logic [1:0]    state_reg, state_next;
    logic [NP-1:0] pend_reg, pend_next;
    logic [NP-1:0] full_reg, full_next;
    logic [PW-1:0] dst_reg [NP];
    logic [PW-1:0] dst_next [NP];
    logic          lock_reg, lock_next;
    logic [PW-1:0] lport_reg, lport_next;
    logic [3:0]    npkt_reg, npkt_next;
    logic [PW-1:0] cport_reg, cport_next;
    logic [PW-1:0] cdst_reg, cdst_next;
    logic [3:0]    cpkt_reg, cpkt_next;
    logic [3:0]    nb_reg, nb_next;
    logic          ovalid_reg, ovalid_next;
    pbfp_pkg::out_t opay_reg, opay_next;

    logic              out_free, acc, emit;
    pbfp_pkg::out_t    res;
    pbfp_pkg::in_t     ip;
    pbfp_pkg::arb_t    pick;
    logic [PW-1:0]     p;
    logic              pv;

    logic              shdr_we, shdr_re, rhdr_we, rhdr_re;
    logic              sdat_we, sdat_re, rdat_we, rdat_re;
    logic [PW-1:0]     shdr_wa, shdr_ra, rhdr_wa, rhdr_ra;
    logic [AW-1:0]     sdat_wa, sdat_ra, rdat_wa, rdat_ra;
    pbfp_pkg::hdr_t    shdr_wd, shdr_rd, rhdr_wd, rhdr_rd;
    logic [63:0]       sdat_rd, rdat_wd, rdat_rd;

    logic [3:0]  nb, k, cnt;
    logic [63:0] w;

    assign out_free  = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign acc       = req.valid && req.ready;
    assign ip        = req.pay;
    assign p         = PW'(ip.port);
    assign pv        = int'(ip.port) < NP;
    assign rsp.valid = ovalid_reg;
    assign rsp.pay   = opay_reg;

    pbfp_arb u_arb (
        .pend (pend_reg),
        .full (full_reg),
        .dst  (dst_reg),
        .pick (pick)
    );

    pbfp_ram #(.WIDTH($bits(pbfp_pkg::hdr_t)), .DEPTH(NP)) u_shdr (
        .clk(clk), .we(shdr_we), .waddr(shdr_wa), .wdata(shdr_wd),
        .re(shdr_re), .raddr(shdr_ra), .rdata(shdr_rd)
    );

    pbfp_ram #(.WIDTH(64), .DEPTH(pbfp_pkg::DATA_DEPTH)) u_sdat (
        .clk(clk), .we(sdat_we), .waddr(sdat_wa), .wdata(ip.data_word),
        .re(sdat_re), .raddr(sdat_ra), .rdata(sdat_rd)
    );

    pbfp_ram #(.WIDTH($bits(pbfp_pkg::hdr_t)), .DEPTH(NP)) u_rhdr (
        .clk(clk), .we(rhdr_we), .waddr(rhdr_wa), .wdata(rhdr_wd),
        .re(rhdr_re), .raddr(rhdr_ra), .rdata(rhdr_rd)
    );

    pbfp_ram #(.WIDTH(64), .DEPTH(pbfp_pkg::DATA_DEPTH)) u_rdat (
        .clk(clk), .we(rdat_we), .waddr(rdat_wa), .wdata(rdat_wd),
        .re(rdat_re), .raddr(rdat_ra), .rdata(rdat_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        full_next  = full_reg;
        dst_next   = dst_reg;
        lock_next  = lock_reg;
        lport_next = lport_reg;
        npkt_next  = npkt_reg;
        cport_next = cport_reg;
        cdst_next  = cdst_reg;
        cpkt_next  = cpkt_reg;
        nb_next    = nb_reg;
        emit       = 1'b0;
        res        = '0;
        shdr_we = 1'b0; shdr_re = 1'b0; rhdr_we = 1'b0; rhdr_re = 1'b0;
        sdat_we = 1'b0; sdat_re = 1'b0; rdat_we = 1'b0; rdat_re = 1'b0;
        shdr_wa = p;
        shdr_ra = cport_reg;
        rhdr_wa = cdst_reg;
        rhdr_ra = p;
        sdat_wa = pbfp_pkg::data_addr(p, 4'(ip.beat_index));
        sdat_ra = pbfp_pkg::data_addr(cport_reg, cpkt_reg - 4'd1);
        rdat_wa = pbfp_pkg::data_addr(cdst_reg, cpkt_reg - 4'd1);
        rdat_ra = pbfp_pkg::data_addr(cport_reg, 4'd0);
        shdr_wd = '{ip.msg_type, ip.line_addr, ip.msg_arg, ip.byte_len};
        rhdr_wd = shdr_rd;
        nb      = '0;
        k       = '0;
        cnt     = '0;
        w       = '0;
        rdat_wd = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (ip.cmd)
                        pbfp_pkg::CMD_LOAD:
                        begin
                            emit = 1'b1;
                            if (pv && int'(ip.beat_index) < pbfp_pkg::MAX_BEATS
                                && !pend_reg[p])
                            begin
                                sdat_we = 1'b1;
                                res.ok  = 1'b1;
                            end
                        end
                        pbfp_pkg::CMD_SEND:
                        begin
                            emit = 1'b1;
                            if (pv && int'(ip.dest) < NP && !pend_reg[p]
                                && int'(ip.byte_len) <= pbfp_pkg::MAX_LEN)
                            begin
                                shdr_we      = 1'b1;
                                pend_next[p] = 1'b1;
                                dst_next[p]  = PW'(ip.dest);
                                res.ok       = 1'b1;
                            end
                        end
                        pbfp_pkg::CMD_TICK:
                        begin
                            if (lock_reg && pend_reg[lport_reg])
                            begin
                                cport_next = lport_reg;
                                cdst_next  = dst_reg[lport_reg];
                                cpkt_next  = npkt_reg;
                                state_next = S_TICK;
                            end
                            else
                            begin
                                lock_next = 1'b0;
                                npkt_next = '0;
                                if (pick.found)
                                begin
                                    cport_next = pick.idx;
                                    cdst_next  = dst_reg[pick.idx];
                                    cpkt_next  = '0;
                                    state_next = S_TICK;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            shdr_re = state_next == S_TICK;
                            sdat_re = state_next == S_TICK;
                            shdr_ra = cport_next;
                            sdat_ra = pbfp_pkg::data_addr(cport_next,
                                                          cpkt_next - 4'd1);
                        end
                        pbfp_pkg::CMD_RECV:
                        begin
                            if (!pv || !full_reg[p])
                            begin
                                emit     = 1'b1;
                                res.last = 1'b1;
                            end
                            else
                            begin
                                rhdr_re    = 1'b1;
                                cport_next = p;
                                state_next = S_RHDR;
                            end
                        end
                        pbfp_pkg::CMD_STATUS:
                        begin
                            emit = 1'b1;
                            if (pv)
                            begin
                                res.ok        = !pend_reg[p];
                                res.recv_free = !full_reg[p];
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                nb = pbfp_pkg::beats_of(shdr_rd.byte_len);
                if (out_free)
                begin
                    emit             = 1'b1;
                    res.ok           = 1'b1;
                    res.src_port     = 4'(cport_reg);
                    res.out_dest     = 4'(cdst_reg);
                    res.packet_index = cpkt_reg;
                    if (cpkt_reg == 4'd0)
                    begin
                        rhdr_we      = 1'b1;
                        res.out_type = shdr_rd.msg_type;
                        res.out_line = shdr_rd.line_addr;
                        res.out_arg  = shdr_rd.msg_arg;
                        res.out_len  = shdr_rd.byte_len;
                    end
                    else
                    begin
                        cnt            = pbfp_pkg::bytes_of(shdr_rd.byte_len,
                                                            cpkt_reg - 4'd1);
                        w              = sdat_rd & pbfp_pkg::byte_mask(cnt);
                        rdat_we        = 1'b1;
                        rdat_wd        = w;
                        res.out_data   = w;
                        res.beat_bytes = cnt;
                    end
                    if (cpkt_reg >= nb)
                    begin
                        res.last            = 1'b1;
                        pend_next[cport_reg] = 1'b0;
                        full_next[cdst_reg]  = 1'b1;
                        lock_next           = 1'b0;
                        npkt_next           = '0;
                    end
                    else
                    begin
                        lock_next  = 1'b1;
                        lport_next = cport_reg;
                        npkt_next  = cpkt_reg + 4'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_RHDR:
            begin
                nb = pbfp_pkg::beats_of(rhdr_rd.byte_len);
                if (out_free)
                begin
                    emit         = 1'b1;
                    res.ok       = 1'b1;
                    res.out_type = rhdr_rd.msg_type;
                    res.out_line = rhdr_rd.line_addr;
                    res.out_arg  = rhdr_rd.msg_arg;
                    res.out_len  = rhdr_rd.byte_len;
                    res.last     = nb == 4'd0;
                    nb_next      = nb;
                    cpkt_next    = '0;
                    if (nb == 4'd0)
                    begin
                        full_next[cport_reg] = 1'b0;
                        state_next           = S_IDLE;
                    end
                    else
                    begin
                        rdat_re    = 1'b1;
                        state_next = S_RDAT;
                    end
                end
            end
            S_RDAT:
            begin
                k   = cpkt_reg + 4'd1;
                cnt = pbfp_pkg::bytes_of(rhdr_rd.byte_len, cpkt_reg);
                if (out_free)
                begin
                    emit             = 1'b1;
                    res.ok           = 1'b1;
                    res.packet_index = k;
                    res.out_data     = rdat_rd & pbfp_pkg::byte_mask(cnt);
                    res.beat_bytes   = cnt;
                    res.last         = k == nb_reg;
                    if (k == nb_reg)
                    begin
                        full_next[cport_reg] = 1'b0;
                        state_next           = S_IDLE;
                    end
                    else
                    begin
                        rdat_re   = 1'b1;
                        rdat_ra   = pbfp_pkg::data_addr(cport_reg, k);
                        cpkt_next = k;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            ovalid_next = 1'b1;
            opay_next   = res;
        end
        else
        begin
            ovalid_next = ovalid_reg && !rsp.ready;
            opay_next   = opay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= '0;
            full_reg   <= '0;
            lock_reg   <= 1'b0;
            lport_reg  <= '0;
            npkt_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NP; i++)
            begin
                dst_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            full_reg   <= full_next;
            lock_reg   <= lock_next;
            lport_reg  <= lport_next;
            npkt_reg   <= npkt_next;
            ovalid_reg <= ovalid_next;
            dst_reg    <= dst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opay_reg  <= opay_next;
        cport_reg <= cport_next;
        cdst_reg  <= cdst_next;
        cpkt_reg  <= cpkt_next;
        nb_reg    <= nb_next;
    end

endmodule
`default_nettype wire

// ===== sv/pbfp_chk.sv =====
`default_nettype none
// ============================================================================
// pbfp_chk
// Port-level checks on the result channel of the packet bus.
// ============================================================================
module pbfp_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire pbfp_pkg::out_t rsp_pay
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    a_pay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_pay))
        else $error("result beat changed while stalled");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_pay.ok |->
            rsp_pay.out_data == 64'd0 && rsp_pay.beat_bytes == 4'd0)
        else $error("refused result carries data");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_pay.packet_index != 4'd0 |->
            rsp_pay.ok && rsp_pay.beat_bytes != 4'd0)
        else $error("data beat without ok or bytes");

endmodule

bind packet_bus_fixed_priority pbfp_chk u_pbfp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_pay   (rsp.pay)
);
`default_nettype wire

// ===== sim/tb_packet_bus_fixed_priority.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_packet_bus_fixed_priority
// Self-checking bench for the fixed-priority packet bus. A directed table
// covers reset state, refusals, full-length and empty messages, and the
// burst lock. Random load/send/tick/receive traffic follows. Every result beat
// is checked against an in-bench model of ports, bus lock and slots, with
// bursty command traffic and a stalling receiver.
// ============================================================================
module tb_packet_bus_fixed_priority;

    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    typedef struct {
        pbfp_pkg::in_t  it;
        bit             typed;
        pbfp_pkg::out_t exp;
    } row_t;

    logic clk;
    logic rst_n;

    pbfp_in_if  req_ch ();
    pbfp_out_if rsp_ch ();

    packet_bus_fixed_priority uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // bus model state
    logic           snd_pend [pbfp_pkg::NUM_PORTS];
    logic [3:0]     snd_dst  [pbfp_pkg::NUM_PORTS];
    pbfp_pkg::hdr_t snd_hdr  [pbfp_pkg::NUM_PORTS];
    logic [63:0]    snd_word [pbfp_pkg::DATA_DEPTH];
    bit             snd_load [pbfp_pkg::DATA_DEPTH];
    logic           rcv_full [pbfp_pkg::NUM_PORTS];
    pbfp_pkg::hdr_t rcv_hdr  [pbfp_pkg::NUM_PORTS];
    logic [63:0]    rcv_word [pbfp_pkg::DATA_DEPTH];
    logic           bus_lock;
    logic [3:0]     lock_port;
    logic [3:0]     next_pkt;

    pbfp_pkg::out_t rsp_expect_q [$];
    int   errors;
    int   items_in;
    bit   held;
    int   burst_left;
    row_t rows [$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_packet_bus_fixed_priority NOT OK");
        $finish;
    end

    function automatic int beat_count(logic [6:0] len);
        return (int'(len) + pbfp_pkg::BUS_BYTES - 1) / pbfp_pkg::BUS_BYTES;
    endfunction

    function automatic logic [3:0] beat_fill(logic [6:0] len, int b);
        int rem;
        rem = int'(len) - b * pbfp_pkg::BUS_BYTES;
        if (rem <= 0)
        begin
            return 4'd0;
        end
        return (rem > pbfp_pkg::BUS_BYTES) ? 4'(pbfp_pkg::BUS_BYTES) : 4'(rem);
    endfunction

    function automatic logic [63:0] fill_mask(logic [3:0] n);
        if (n >= 4'd8)
        begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int loaded_prefix(int p);
        int k;
        k = 0;
        while (k < pbfp_pkg::MAX_BEATS && snd_load[p * pbfp_pkg::MAX_BEATS + k])
        begin
            k++;
        end
        return k;
    endfunction

    function automatic pbfp_pkg::out_t move_packet(int src, int pkt);
        pbfp_pkg::out_t r;
        int   dst;
        int   b;
        logic [6:0] len;
        r = '0;
        dst = snd_dst[src];
        len = snd_hdr[src].byte_len;
        r.ok = 1'b1;
        r.src_port = 4'(src);
        r.out_dest = 4'(dst);
        r.packet_index = 4'(pkt);
        if (pkt == 0)
        begin
            rcv_hdr[dst] = snd_hdr[src];
            r.out_type = snd_hdr[src].msg_type;
            r.out_line = snd_hdr[src].line_addr;
            r.out_arg = snd_hdr[src].msg_arg;
            r.out_len = len;
        end
        else if (pkt - 1 < pbfp_pkg::MAX_BEATS)
        begin
            b = pkt - 1;
            r.beat_bytes = beat_fill(len, b);
            r.out_data = snd_word[src * pbfp_pkg::MAX_BEATS + b]
                         & fill_mask(r.beat_bytes);
            rcv_word[dst * pbfp_pkg::MAX_BEATS + b] = r.out_data;
        end
        if (pkt + 1 >= beat_count(len) + 1)
        begin
            r.last = 1'b1;
            snd_pend[src] = 1'b0;
            rcv_full[dst] = 1'b1;
            bus_lock = 1'b0;
            next_pkt = '0;
        end
        else
        begin
            bus_lock = 1'b1;
            lock_port = 4'(src);
            next_pkt = 4'(pkt + 1);
        end
        return r;
    endfunction

    function automatic void bus_step(pbfp_pkg::in_t it, bit push);
        pbfp_pkg::out_t r;
        int   p;
        int   nb;
        r = '0;
        p = it.port;
        case (it.cmd)
            pbfp_pkg::CMD_LOAD:
            begin
                if (!snd_pend[p])
                begin
                    snd_word[p * pbfp_pkg::MAX_BEATS + it.beat_index] = it.data_word;
                    snd_load[p * pbfp_pkg::MAX_BEATS + it.beat_index] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            pbfp_pkg::CMD_SEND:
            begin
                if (!snd_pend[p] && it.byte_len <= pbfp_pkg::MAX_LEN)
                begin
                    snd_pend[p] = 1'b1;
                    snd_dst[p] = it.dest;
                    snd_hdr[p] = '{it.msg_type, it.line_addr, it.msg_arg,
                                   it.byte_len};
                    r.ok = 1'b1;
                end
            end
            pbfp_pkg::CMD_TICK:
            begin
                if (bus_lock && snd_pend[lock_port])
                begin
                    r = move_packet(lock_port, next_pkt);
                end
                else
                begin
                    bus_lock = 1'b0;
                    next_pkt = '0;
                    for (int i = 0; i < pbfp_pkg::NUM_PORTS; i++)
                    begin
                        if (snd_pend[i] && !rcv_full[snd_dst[i]])
                        begin
                            r = move_packet(i, 0);
                            break;
                        end
                    end
                end
            end
            pbfp_pkg::CMD_RECV:
            begin
                if (!rcv_full[p])
                begin
                    r.last = 1'b1;
                end
                else
                begin
                    nb = beat_count(rcv_hdr[p].byte_len);
                    r.ok = 1'b1;
                    r.out_type = rcv_hdr[p].msg_type;
                    r.out_line = rcv_hdr[p].line_addr;
                    r.out_arg = rcv_hdr[p].msg_arg;
                    r.out_len = rcv_hdr[p].byte_len;
                    r.last = (nb == 0);
                    if (push && nb > 0)
                    begin
                        rsp_expect_q.push_back(r);
                    end
                    for (int b = 0; b < nb; b++)
                    begin
                        r = '0;
                        r.ok = 1'b1;
                        r.packet_index = 4'(b + 1);
                        r.beat_bytes = beat_fill(rcv_hdr[p].byte_len, b);
                        r.out_data = rcv_word[p * pbfp_pkg::MAX_BEATS + b]
                                     & fill_mask(r.beat_bytes);
                        r.last = (b + 1 == nb);
                        if (push && b + 1 < nb)
                        begin
                            rsp_expect_q.push_back(r);
                        end
                    end
                    rcv_full[p] = 1'b0;
                end
            end
            pbfp_pkg::CMD_STATUS:
            begin
                r.ok = !snd_pend[p];
                r.recv_free = !rcv_full[p];
            end
            default:
            begin
            end
        endcase
        if (push)
        begin
            rsp_expect_q.push_back(r);
        end
    endfunction

    function automatic pbfp_pkg::in_t mk_item(logic [2:0] cmd, int p, int d, int len,
                                              int b, logic [63:0] w);
        pbfp_pkg::in_t it;
        it.cmd = cmd;
        it.port = 4'(p);
        it.dest = 4'(d);
        it.msg_type = 8'($urandom);
        it.line_addr = {$urandom, $urandom};
        it.msg_arg = $urandom;
        it.byte_len = 7'(len);
        it.beat_index = 3'(b);
        it.data_word = w;
        return it;
    endfunction

    function automatic int pick_port();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    endfunction

    function automatic pbfp_pkg::in_t random_item();
        pbfp_pkg::in_t it;
        int  sel;
        int  lp;
        int  full_ports [$];
        sel = $urandom_range(0, 99);
        it = mk_item(pbfp_pkg::CMD_LOAD, pick_port(), pick_port(), $urandom_range(0, 64),
                     $urandom_range(0, 7), {$urandom, $urandom});
        if (sel < 30)
        begin
            it.cmd = pbfp_pkg::CMD_LOAD;
        end
        else if (sel < 50)
        begin
            it.cmd = pbfp_pkg::CMD_SEND;
            if ($urandom_range(0, 9) == 0)
            begin
                it.byte_len = 7'($urandom_range(65, 127));
            end
            if (!snd_pend[it.port] && it.byte_len <= pbfp_pkg::MAX_LEN)
            begin
                lp = loaded_prefix(it.port);
                if (beat_count(it.byte_len) > lp)
                begin
                    it.byte_len = 7'($urandom_range(0, lp * pbfp_pkg::BUS_BYTES));
                end
            end
        end
        else if (sel < 82)
        begin
            it.cmd = pbfp_pkg::CMD_TICK;
        end
        else if (sel < 94)
        begin
            it.cmd = pbfp_pkg::CMD_RECV;
            for (int i = 0; i < pbfp_pkg::NUM_PORTS; i++)
            begin
                if (rcv_full[i])
                begin
                    full_ports.push_back(i);
                end
            end
            if (full_ports.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                it.port = 4'(full_ports[$urandom_range(0, full_ports.size() - 1)]);
            end
        end
        else if (sel < 97)
        begin
            it.cmd = pbfp_pkg::CMD_STATUS;
        end
        else
        begin
            it.cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        end
        return it;
    endfunction

    function automatic void add_row(pbfp_pkg::in_t it, bit typed, pbfp_pkg::out_t exp);
        row_t r;
        r.it = it;
        r.typed = typed;
        r.exp = exp;
        rows.push_back(r);
    endfunction

    function automatic pbfp_pkg::out_t res(logic ok, logic last, logic rfree);
        pbfp_pkg::out_t r;
        r = '0;
        r.ok = ok;
        r.last = last;
        r.recv_free = rfree;
        return r;
    endfunction

    task automatic drive(pbfp_pkg::in_t it);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        req_ch.valid <= 1'b1;
        req_ch.pay <= it;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        items_in++;
    endtask

    task automatic note_fail(string what, pbfp_pkg::out_t e, pbfp_pkg::out_t a);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t mismatch (%s): exp %h act %h", $realtime, what, e, a);
        end
    endtask

    always @(posedge clk)
    begin : result_mon
        pbfp_pkg::out_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_expect_q.size() == 0)
            begin
                note_fail("unexpected beat", '0, rsp_ch.pay);
            end
            else
            begin
                e = rsp_expect_q[0];
                rsp_expect_q.delete(0);
                if (e !== rsp_ch.pay)
                begin
                    note_fail("field", e, rsp_ch.pay);
                end
            end
        end
    end

    initial
    begin : rx_side
        int mode;
        int left;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(20, 80);
            while (left > 0)
            begin
                @(posedge clk);
                if (!held && items_in >= 60)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (300) @(posedge clk);
                    held = 1'b1;
                end
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= (left % 4 == 0);
                endcase
                left--;
            end
        end
    end

    initial
    begin : tx_side
        pbfp_pkg::in_t it;
        for (int i = 0; i < pbfp_pkg::NUM_PORTS; i++)
        begin
            snd_pend[i] = 1'b0;
            snd_dst[i] = '0;
            rcv_full[i] = 1'b0;
        end
        for (int i = 0; i < pbfp_pkg::DATA_DEPTH; i++)
        begin
            snd_load[i] = 1'b0;
        end
        bus_lock = 1'b0;
        lock_port = '0;
        next_pkt = '0;
        errors = 0;
        items_in = 0;
        burst_left = 0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.pay <= '0;

        add_row(mk_item(pbfp_pkg::CMD_STATUS, 0, 0, 0, 0, '0), 1, res(1, 0, 1));
        add_row(mk_item(pbfp_pkg::CMD_RECV, 5, 0, 0, 0, '0), 1, res(0, 1, 0));
        add_row(mk_item(pbfp_pkg::CMD_TICK, 0, 0, 0, 0, '0), 1, res(0, 0, 0));
        add_row(mk_item(CMD_BAD_LO, 3, 0, 0, 0, '0), 1, res(0, 0, 0));
        add_row(mk_item(CMD_BAD_HI, 15, 15, 127, 7, '1), 1, res(0, 0, 0));
        for (int b = 0; b < pbfp_pkg::MAX_BEATS; b++)
        begin
            add_row(mk_item(pbfp_pkg::CMD_LOAD, 0, 0, 0, b,
                            (b == 0) ? '1 : (b == 7) ? '0 : {$urandom, $urandom}),
                    1, res(1, 0, 0));
        end
        add_row(mk_item(pbfp_pkg::CMD_LOAD, 15, 0, 0, 7, {$urandom, $urandom}), 1,
                res(1, 0, 0));
        it = mk_item(pbfp_pkg::CMD_SEND, 0, 15, 64, 0, '0);
        it.msg_type = '1;
        it.line_addr = '1;
        it.msg_arg = '1;
        add_row(it, 1, res(1, 0, 0));
        add_row(mk_item(pbfp_pkg::CMD_SEND, 0, 1, 8, 0, '0), 1, res(0, 0, 0));
        add_row(mk_item(pbfp_pkg::CMD_LOAD, 0, 0, 0, 3, '1), 1, res(0, 0, 0));
        add_row(mk_item(pbfp_pkg::CMD_SEND, 1, 2, 65, 0, '0), 1, res(0, 0, 0));
        add_row(mk_item(pbfp_pkg::CMD_SEND, 2, 3, 127, 0, '0), 1, res(0, 0, 0));
        it = mk_item(pbfp_pkg::CMD_SEND, 15, 0, 0, 0, '0);
        it.msg_type = '0;
        it.line_addr = '0;
        it.msg_arg = '0;
        add_row(it, 1, res(1, 0, 0));
        for (int t = 0; t < pbfp_pkg::MAX_BEATS + 2; t++)
        begin
            add_row(mk_item(pbfp_pkg::CMD_TICK, 0, 0, 0, 0, '0), 0, '0);
        end
        add_row(mk_item(pbfp_pkg::CMD_RECV, 15, 0, 0, 0, '0), 0, '0);
        add_row(mk_item(pbfp_pkg::CMD_RECV, 0, 0, 0, 0, '0), 0, '0);
        add_row(mk_item(pbfp_pkg::CMD_STATUS, 15, 0, 0, 0, '0), 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            drive(rows[i].it);
            bus_step(rows[i].it, !rows[i].typed);
            if (rows[i].typed)
            begin
                rsp_expect_q.push_back(rows[i].exp);
            end
        end
        repeat (300)
        begin
            it = random_item();
            drive(it);
            bus_step(it, 1'b1);
        end
        req_ch.valid <= 1'b0;
        while (rsp_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_packet_bus_fixed_priority OK");
        end
        else
        begin
            $display("tb_packet_bus_fixed_priority NOT OK");
        end
        $finish;
    end
endmodule
